/* hw/rtl/slot_pool_oldest_evict_core_defines.svh */
// ----------------------------------------------------------------------------
// slot pool assertion macros
// shared assertion wrappers for the slot pool rtl
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_OLDEST_EVICT_CORE_DEFINES_SVH
`define SLOT_POOL_OLDEST_EVICT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPOE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SPOE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/spoe_pkg.sv */
// ----------------------------------------------------------------------------
// spoe_pkg
// types and constants shared by the slot pool rtl
// ----------------------------------------------------------------------------
package spoe_pkg;

   localparam int POOL_SLOTS_DEF = 16;
   localparam int STAMP_BITS_DEF = 32;
   localparam int SLOT_PORT_W    = 4;
   localparam int SIZE_PORT_W    = 5;
   localparam int ERR_W          = 2;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_FREE  = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_EVICT,
      ST_POP_RD,
      ST_POP,
      ST_OUT
   } state_type;

   // control from the sequencer to the stamp unit
   typedef struct packed {
      logic clear;    // restart the oldest search
      logic rd_en;    // read one stamp for comparison
      logic rd_live;  // slot being read is in use
   } scan_ctl_type;

endpackage

/* hw/rtl/spoe_stamp_unit.sv */
// ----------------------------------------------------------------------------
// spoe_stamp_unit
// per-slot stamp memory with one shared comparator for the oldest search
// ----------------------------------------------------------------------------
module spoe_stamp_unit
   import spoe_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF,
   parameter int STAMP_BITS = STAMP_BITS_DEF,
   localparam int SLOT_W    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scan_ctl_type          scan_ctl,
   input  logic [SLOT_W-1:0]     rd_idx,
   input  logic                  wr_en,
   input  logic [SLOT_W-1:0]     wr_idx,
   input  logic [STAMP_BITS-1:0] wr_stamp,
   output logic [SLOT_W-1:0]     best_idx
);

   logic [STAMP_BITS-1:0] stamp_mem [POOL_SLOTS];

   logic [STAMP_BITS-1:0] rd_stamp_ff;
   logic [SLOT_W-1:0]     rd_idx_ff;
   logic                  rd_live_ff;
   logic                  cmp_vld_ff;

   logic [STAMP_BITS-1:0] best_stamp_ff, best_stamp_in;
   logic [SLOT_W-1:0]     best_idx_ff, best_idx_in;
   logic                  found_ff, found_in;
   logic                  take;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_mem[wr_idx] <= wr_stamp;
      end
      if (scan_ctl.rd_en) begin
         rd_stamp_ff <= stamp_mem[rd_idx];
         rd_idx_ff   <= rd_idx;
      end
   end

   // one compare per cycle against the running minimum
   assign take = cmp_vld_ff && rd_live_ff && (!found_ff || (rd_stamp_ff < best_stamp_ff));

   always_comb begin
      best_stamp_in = best_stamp_ff;
      best_idx_in   = best_idx_ff;
      found_in      = found_ff;
      if (scan_ctl.clear) begin
         best_idx_in = '0;
         found_in    = 1'b0;
      end else if (take) begin
         best_stamp_in = rd_stamp_ff;
         best_idx_in   = rd_idx_ff;
         found_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff  <= 1'b0;
         cmp_vld_ff  <= 1'b0;
         best_idx_ff <= '0;
         found_ff    <= 1'b0;
      end else begin
         rd_live_ff  <= scan_ctl.rd_live;
         cmp_vld_ff  <= scan_ctl.rd_en;
         best_idx_ff <= best_idx_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_stamp_ff <= best_stamp_in;
   end

   assign best_idx = best_idx_ff;

endmodule

/* hw/rtl/slot_pool_oldest_evict_core.sv */
// ----------------------------------------------------------------------------
// slot_pool_oldest_evict_core
// slot allocator with a free-slot stack and oldest-first eviction when full
// ----------------------------------------------------------------------------
// usage:
//   req_ channel carries one request: req_operation selects allocate or
//   release, req_slot_index names the slot to release. a request is taken
//   when req_valid is high and req_stall is low. rsp_ channel returns one
//   response per request (granted slot, eviction flag and slot, error code),
//   taken when rsp_valid is high and rsp_stall is low.
//   csr_ channel writes the pool size; a write resets the free stack and all
//   slot states but keeps the stamp counter. write only while idle.
// states per request, in order:
//   release                      exec, out
//   allocate, pool not full      exec, pop rd, pop, out
//   allocate, pool full          exec, scan, scan last, evict, pop rd, pop,
//                                out; the scan reads one slot stamp per
//                                cycle via a single read port and comparator
// one request is in flight at a time; req_stall is high while it is worked.
// a finished response waits in an output register, so a new request is taken
// while the receiver stalls; the block then holds the following response
// until the output register frees.
// reset is synchronous: pool size returns to min(POOL_SLOTS, 16), all slots
// are free and the stamp counter is zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "slot_pool_oldest_evict_core_defines.svh"

module slot_pool_oldest_evict_core
   import spoe_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF,
   parameter int STAMP_BITS = STAMP_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [SLOT_PORT_W-1:0] req_slot_index,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SLOT_PORT_W-1:0] rsp_granted_slot,
   output logic                   rsp_evicted,
   output logic [SLOT_PORT_W-1:0] rsp_evicted_slot,
   output logic [ERR_W-1:0]       rsp_error_code,
   // pool size register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SIZE_PORT_W-1:0] csr_pool_size
);

   localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int SIZE_W     = $clog2(POOL_SLOTS + 1);
   localparam int CMP_W      = (SIZE_W > SIZE_PORT_W) ? SIZE_W : SIZE_PORT_W;
   localparam int RESET_SIZE = (POOL_SLOTS < 16) ? POOL_SLOTS : 16;

   // sequencer and pool state
   state_type             state_ff, state_in;
   op_type                op_ff;
   logic [SLOT_PORT_W-1:0] slot_ff;
   logic [SIZE_W-1:0]     pool_size_ff, pool_size_in;
   logic [SIZE_W-1:0]     used_count_ff, used_count_in;
   logic [POOL_SLOTS-1:0] used_ff, used_in;      // slot is in use
   logic [POOL_SLOTS-1:0] stk_vld_ff, stk_vld_in; // stack entry was written
   logic [STAMP_BITS-1:0] stamp_cnt_ff, stamp_cnt_in;
   logic [SLOT_W-1:0]     scan_idx_ff, scan_idx_in;

   // pending result
   logic [SLOT_PORT_W-1:0] res_granted_ff, res_granted_in;
   logic                   res_ev_ff, res_ev_in;
   logic [SLOT_PORT_W-1:0] res_evslot_ff, res_evslot_in;
   logic [ERR_W-1:0]       res_err_ff, res_err_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_load;
   logic [SLOT_PORT_W-1:0] rsp_granted_ff;
   logic                   rsp_ev_ff;
   logic [SLOT_PORT_W-1:0] rsp_evslot_ff;
   logic [ERR_W-1:0]       rsp_err_ff;

   // free stack memory
   logic [SLOT_W-1:0]     stack_mem [POOL_SLOTS];
   logic                  stk_we;
   logic [SLOT_W-1:0]     stk_waddr;
   logic [SLOT_W-1:0]     stk_wdata;
   logic                  stk_re;
   logic [SLOT_W-1:0]     stk_rdata_ff;
   logic [SLOT_W-1:0]     pop_idx, pop_idx_ff;
   logic                  pop_vld_ff;

   // stamp unit
   scan_ctl_type          scan_ctl;
   logic [SLOT_W-1:0]     scan_rd_idx;
   logic                  stamp_we;
   logic [SLOT_W-1:0]     stamp_widx;
   logic [SLOT_W-1:0]     best_idx;

   // helpers
   logic                  req_take, csr_take;
   logic [SIZE_W-1:0]     depth, depth_m1;
   logic [CMP_W-1:0]      csr_ext, slot_ext, scan_ext, granted_ext, best_ext;
   logic [SLOT_W-1:0]     granted;
   logic [STAMP_BITS-1:0] stamp_inc;

   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;

   // free entries; the stack top sits at depth - 1
   assign depth    = pool_size_ff - used_count_ff;
   assign depth_m1 = depth - SIZE_W'(1);
   assign pop_idx  = (depth != '0) ? depth_m1[SLOT_W-1:0] : '0;

   assign csr_ext     = CMP_W'(csr_pool_size);
   assign slot_ext    = CMP_W'(slot_ff);
   assign scan_ext    = CMP_W'(scan_idx_ff);
   assign granted     = pop_vld_ff ? stk_rdata_ff : pop_idx_ff;
   assign granted_ext = CMP_W'(granted);
   assign best_ext    = CMP_W'(best_idx);
   assign scan_rd_idx = scan_idx_ff;

   // counter skips zero when it wraps
   assign stamp_inc = stamp_cnt_ff + STAMP_BITS'(1);

   always_comb begin
      state_in       = state_ff;
      pool_size_in   = pool_size_ff;
      used_count_in  = used_count_ff;
      used_in        = used_ff;
      stk_vld_in     = stk_vld_ff;
      stamp_cnt_in   = stamp_cnt_ff;
      scan_idx_in    = scan_idx_ff;
      res_granted_in = res_granted_ff;
      res_ev_in      = res_ev_ff;
      res_evslot_in  = res_evslot_ff;
      res_err_in     = res_err_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_load       = 1'b0;
      stk_we         = 1'b0;
      stk_waddr      = depth[SLOT_W-1:0];
      stk_wdata      = '0;
      stk_re         = 1'b0;
      scan_ctl       = '0;
      stamp_we       = 1'b0;
      stamp_widx     = granted;

      case (state_ff)
         ST_IDLE: begin
            if (csr_take) begin
               // clamp to 1..POOL_SLOTS and reinitialise the pool
               if (csr_ext == '0) begin
                  pool_size_in = SIZE_W'(1);
               end else if (csr_ext > CMP_W'(POOL_SLOTS)) begin
                  pool_size_in = SIZE_W'(POOL_SLOTS);
               end else begin
                  pool_size_in = csr_ext[SIZE_W-1:0];
               end
               used_in       = '0;
               stk_vld_in    = '0;
               used_count_in = '0;
            end else if (req_take) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_granted_in = '0;
            res_ev_in      = 1'b0;
            res_evslot_in  = '0;
            res_err_in     = ERR_OK;
            if (op_ff == OP_RELEASE) begin
               state_in = ST_OUT;
               if (slot_ext >= CMP_W'(pool_size_ff)) begin
                  res_err_in = ERR_RANGE;
               end else if (!used_ff[slot_ext[SLOT_W-1:0]]) begin
                  res_err_in = ERR_FREE;
               end else begin
                  // push back onto the free stack
                  if (depth < SIZE_W'(POOL_SLOTS)) begin
                     stk_we                           = 1'b1;
                     stk_wdata                        = slot_ext[SLOT_W-1:0];
                     stk_vld_in[depth[SLOT_W-1:0]]    = 1'b1;
                     used_in[slot_ext[SLOT_W-1:0]]    = 1'b0;
                  end
                  if (used_count_ff != '0) begin
                     used_count_in = used_count_ff - SIZE_W'(1);
                  end
               end
            end else if (used_count_ff >= pool_size_ff) begin
               // pool full: search for the oldest stamp first
               scan_ctl.clear = 1'b1;
               scan_idx_in    = '0;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_POP_RD;
            end
         end

         ST_SCAN: begin
            scan_ctl.rd_en   = 1'b1;
            scan_ctl.rd_live = used_ff[scan_idx_ff];
            if (scan_ext == (CMP_W'(pool_size_ff) - CMP_W'(1))) begin
               state_in = ST_SCAN_LAST;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_W'(1);
            end
         end

         ST_SCAN_LAST: begin
            // last stamp compare completes this cycle
            state_in = ST_EVICT;
         end

         ST_EVICT: begin
            res_ev_in     = 1'b1;
            res_evslot_in = best_ext[SLOT_PORT_W-1:0];
            if (depth < SIZE_W'(POOL_SLOTS)) begin
               stk_we                        = 1'b1;
               stk_wdata                     = best_idx;
               stk_vld_in[depth[SLOT_W-1:0]] = 1'b1;
               used_in[best_idx]             = 1'b0;
            end
            if (used_count_ff != '0) begin
               used_count_in = used_count_ff - SIZE_W'(1);
            end
            state_in = ST_POP_RD;
         end

         ST_POP_RD: begin
            stk_re   = 1'b1;
            state_in = ST_POP;
         end

         ST_POP: begin
            res_granted_in = granted_ext[SLOT_PORT_W-1:0];
            used_in[granted] = 1'b1;
            used_count_in  = used_count_ff + SIZE_W'(1);
            stamp_cnt_in   = (stamp_inc == '0) ? STAMP_BITS'(1) : stamp_inc;
            stamp_we       = 1'b1;
            state_in       = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pool_size_ff  <= SIZE_W'(RESET_SIZE);
         used_count_ff <= '0;
         used_ff       <= '0;
         stk_vld_ff    <= '0;
         stamp_cnt_ff  <= '0;
         scan_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pool_size_ff  <= pool_size_in;
         used_count_ff <= used_count_in;
         used_ff       <= used_in;
         stk_vld_ff    <= stk_vld_in;
         stamp_cnt_ff  <= stamp_cnt_in;
         scan_idx_ff   <= scan_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= op_type'(req_operation);
         slot_ff <= req_slot_index;
      end
      res_granted_ff <= res_granted_in;
      res_ev_ff      <= res_ev_in;
      res_evslot_ff  <= res_evslot_in;
      res_err_ff     <= res_err_in;
      if (rsp_load) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_ev_ff      <= res_ev_ff;
         rsp_evslot_ff  <= res_evslot_ff;
         rsp_err_ff     <= res_err_ff;
      end
   end

   // free stack: one write and one registered read port
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rdata_ff <= stack_mem[pop_idx];
         pop_idx_ff   <= pop_idx;
         pop_vld_ff   <= stk_vld_ff[pop_idx];
      end
   end

   spoe_stamp_unit #(
      .POOL_SLOTS (POOL_SLOTS),
      .STAMP_BITS (STAMP_BITS)
   ) u_stamp (
      .clock    (clock),
      .reset    (reset),
      .scan_ctl (scan_ctl),
      .rd_idx   (scan_rd_idx),
      .wr_en    (stamp_we),
      .wr_idx   (stamp_widx),
      .wr_stamp (stamp_cnt_in),
      .best_idx (best_idx)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_evicted      = rsp_ev_ff;
   assign rsp_evicted_slot = rsp_evslot_ff;
   assign rsp_error_code   = rsp_err_ff;

   // in-use bits and the in-use count agree between requests
   `SPOE_ASSERT_IMP(a_count_match, clock, reset, state_ff == ST_IDLE,
      $countones(used_ff) == int'(used_count_ff), "in-use count out of step")

   // the pool never holds more slots than its size
   `SPOE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      used_count_ff <= pool_size_ff, "in-use count above pool size")

   // an eviction regrants the slot it just freed
   `SPOE_ASSERT_IMP(a_evict_regrant, clock, reset, state_ff == ST_OUT && res_ev_ff,
      res_granted_ff == res_evslot_ff, "evicted slot not regranted")

   // an allocate into a full pool always goes through the stamp scan
   `SPOE_ASSERT_NXT(a_full_scans, clock, reset,
      state_ff == ST_EXEC && op_ff == OP_ALLOC && used_count_ff >= pool_size_ff,
      state_ff == ST_SCAN, "full pool allocate skipped the scan")

endmodule

/* tb/slot_pool_oldest_evict_checker.sv */
// ----------------------------------------------------------------------------
// slot pool response checker
// watches the request, response and pool size channels, keeps its own model
// of the free stack and slot stamps, and compares every response with it
// ----------------------------------------------------------------------------
module slot_pool_oldest_evict_checker
   import spoe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_operation,
   input  logic [SLOT_PORT_W-1:0] req_slot_index,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [SLOT_PORT_W-1:0] rsp_granted_slot,
   input  logic                   rsp_evicted,
   input  logic [SLOT_PORT_W-1:0] rsp_evicted_slot,
   input  logic [ERR_W-1:0]       rsp_error_code,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [SIZE_PORT_W-1:0] csr_pool_size,
   output int                     fail_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOTS = POOL_SLOTS_DEF;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [SLOT_PORT_W-1:0] granted_slot;
      logic                   evicted;
      logic [SLOT_PORT_W-1:0] evicted_slot;
      logic [ERR_W-1:0]       error_code;
   } grant_type;

   int                        live_size;
   int                        used_count;
   logic [SLOT_PORT_W-1:0]    free_stack [NSLOTS];
   logic [STAMP_BITS_DEF-1:0] slot_stamp [NSLOTS];
   logic [STAMP_BITS_DEF-1:0] stamp_counter;
   grant_type                 owed_grants [$];

   function automatic void clear_slots();
      for (int i = 0; i < NSLOTS; i++) begin
         free_stack[i] = SLOT_PORT_W'(i);
         slot_stamp[i] = '0;
      end
      used_count = 0;
   endfunction

   // push a slot back on the free stack and mark it free
   function automatic void put_back(int s);
      int depth;
      depth = live_size - used_count;
      if (depth < NSLOTS) begin
         free_stack[depth] = SLOT_PORT_W'(s);
         slot_stamp[s] = '0;
      end
      if (used_count > 0) used_count--;
   endfunction

   function automatic grant_type serve_request(op_type op, logic [SLOT_PORT_W-1:0] slot);
      grant_type                 res;
      int                        depth;
      int                        idx;
      int                        victim;
      logic                      found;
      logic [STAMP_BITS_DEF-1:0] oldest;
      res = '0;
      res.error_code = ERR_OK;
      if (op == OP_ALLOC) begin
         if (used_count >= live_size) begin
            // pool full: the smallest live stamp is the oldest allocation
            victim = 0;
            found = 1'b0;
            oldest = '0;
            for (int i = 0; i < live_size; i++) begin
               if (slot_stamp[i] != 0 && (!found || slot_stamp[i] < oldest)) begin
                  oldest = slot_stamp[i];
                  victim = i;
                  found = 1'b1;
               end
            end
            res.evicted = 1'b1;
            res.evicted_slot = SLOT_PORT_W'(victim);
            put_back(victim);
         end
         depth = live_size - used_count;
         idx = (depth >= 1 && depth <= NSLOTS) ? depth - 1 : 0;
         res.granted_slot = free_stack[idx];
         used_count++;
         stamp_counter = stamp_counter + 1'b1;
         if (stamp_counter == 0) stamp_counter = 1;
         slot_stamp[res.granted_slot] = stamp_counter;
      end else begin
         if (slot >= live_size) res.error_code = ERR_RANGE;
         else if (slot_stamp[slot] == 0) res.error_code = ERR_FREE;
         else put_back(slot);
      end
      return res;
   endfunction

   function automatic void log_failure(string what, grant_type want, grant_type got);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("[%0t] %s: expected grant %0d evict %0b/%0d err %0d,", $realtime, what,
                  want.granted_slot, want.evicted, want.evicted_slot, want.error_code,
                  " got grant %0d evict %0b/%0d err %0d",
                  got.granted_slot, got.evicted, got.evicted_slot, got.error_code);
   endfunction

   always @(posedge clock) begin : watch
      grant_type got;
      grant_type want;
      if (reset) begin
         live_size = NSLOTS;
         stamp_counter = '0;
         clear_slots();
         owed_grants.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_pool_size == 0) live_size = 1;
            else if (csr_pool_size > NSLOTS) live_size = NSLOTS;
            else live_size = csr_pool_size;
            clear_slots();
         end
         if (rsp_valid && !rsp_stall) begin
            got.granted_slot = rsp_granted_slot;
            got.evicted = rsp_evicted;
            got.evicted_slot = rsp_evicted_slot;
            got.error_code = rsp_error_code;
            if (owed_grants.size() == 0) begin
               log_failure("response with no request waiting", '0, got);
            end else begin
               want = owed_grants.pop_front();
               if (got !== want) log_failure("response mismatch", want, got);
            end
         end
         if (req_valid && !req_stall)
            owed_grants.push_back(serve_request(op_type'(req_operation), req_slot_index));
      end
      outstanding = owed_grants.size();
   end

endmodule

/* tb/slot_pool_oldest_evict_core_test.sv */
// ----------------------------------------------------------------------------
// slot pool allocator test
// drives allocate and release requests through several pool sizes, with
// random idling on both channels and one long response hold-off; a checker
// beside the block predicts and compares every response
// ----------------------------------------------------------------------------
module slot_pool_oldest_evict_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import spoe_pkg::*;

   localparam int PHASES         = 16;
   localparam int PHASE_REQUESTS = 125;
   localparam int HOLD_CYCLES    = 400;   // long response hold-off
   localparam int DRAIN_CYCLES   = 40;    // extra idle time after the drain
   localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
   localparam int IDLE_PERCENT   = 25;
   localparam int ALLOC_PERCENT  = 55;
   localparam int IN_POOL_PERCENT = 75;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_operation;
   logic [SLOT_PORT_W-1:0] req_slot_index;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [SLOT_PORT_W-1:0] rsp_granted_slot;
   logic                   rsp_evicted;
   logic [SLOT_PORT_W-1:0] rsp_evicted_slot;
   logic [ERR_W-1:0]       rsp_error_code;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [SIZE_PORT_W-1:0] csr_pool_size;

   int fail_count;
   int outstanding;

   // stimulus bookkeeping
   int allocs_sent;
   int releases_sent;
   int size_writes;
   int pool_span;       // slots the block uses after clamping the last write
   bit calm;            // no idling on either side
   bit want_hold;       // ask the response side for the long hold-off

   // pool sizes per random phase; every fourth one is drawn at random
   int phase_sizes [PHASES] = '{16, 1, 31, 0, 0, 2, 16, 0, 5, 12, 20, 0, 3, 9, 16, 0};

   slot_pool_oldest_evict_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_slot (rsp_evicted_slot),
      .rsp_error_code   (rsp_error_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_pool_size    (csr_pool_size)
   );

   slot_pool_oldest_evict_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_slot (rsp_evicted_slot),
      .rsp_error_code   (rsp_error_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_pool_size    (csr_pool_size),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // offer one request and hold it until the block takes it
   task automatic send_request(op_type op, logic [SLOT_PORT_W-1:0] slot);
      req_valid <= 1'b1;
      req_operation <= op;
      req_slot_index <= slot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_ALLOC) allocs_sent++;
      else releases_sent++;
   endtask

   // drop valid and wait until every request has its response back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // pool size write, only with the block idle
   task automatic write_pool_size(logic [SIZE_PORT_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_pool_size <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      size_writes++;
      // mirror the block's clamping so releases can aim inside the pool
      if (value == 0) pool_span = 1;
      else if (value > POOL_SLOTS_DEF) pool_span = POOL_SLOTS_DEF;
      else pool_span = value;
   endtask

   // response side: random stalls, or one long hold-off when asked
   initial begin : rsp_side
      forever begin
         if (want_hold) begin
            want_hold = 1'b0;
            rsp_stall <= 1'b1;
            for (int held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
            @(posedge clock);
         end
      end
   end

   // ends the run if nothing is accepted for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      op_type                 op;
      logic [SLOT_PORT_W-1:0] slot;
      logic [SIZE_PORT_W-1:0] size_val;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_ALLOC;
      req_slot_index <= '0;
      csr_valid <= 1'b0;
      csr_pool_size <= '0;
      pool_span = POOL_SLOTS_DEF;
      calm = 1'b0;
      want_hold = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset pool of 16: releases of free slots, then two grants and a double
      // release of the first granted slot
      send_request(OP_RELEASE, 4'd15);
      send_request(OP_RELEASE, 4'd5);
      send_request(OP_ALLOC, 4'($urandom));
      send_request(OP_ALLOC, 4'($urandom));
      send_request(OP_RELEASE, 4'd15);
      send_request(OP_RELEASE, 4'd15);

      // zero clamps to a one-slot pool: the second allocate evicts,
      // releases beyond the pool are rejected
      write_pool_size(5'd0);
      send_request(OP_ALLOC, 4'd0);
      send_request(OP_ALLOC, 4'd15);
      send_request(OP_RELEASE, 4'd0);
      send_request(OP_RELEASE, 4'd0);
      send_request(OP_RELEASE, 4'd1);
      send_request(OP_RELEASE, 4'd15);

      // three slots: fill, evict the oldest, release edge slots
      write_pool_size(5'd3);
      repeat (4) send_request(OP_ALLOC, 4'($urandom));
      send_request(OP_RELEASE, 4'd2);
      send_request(OP_RELEASE, 4'd3);

      // all ones clamps to the full pool
      write_pool_size(5'd31);
      send_request(OP_RELEASE, 4'd15);
      send_request(OP_ALLOC, 4'($urandom));
      send_request(OP_RELEASE, 4'd10);

      // random phases, one pool size write each
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph % 4 == 3) size_val = SIZE_PORT_W'($urandom_range(0, 31));
         else size_val = SIZE_PORT_W'(phase_sizes[ph]);
         write_pool_size(size_val);
         // receiver holds off while requests keep coming, so the block fills
         if (ph == 2) want_hold = 1'b1;
         // one phase with no idling at all
         calm = (ph == 5);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end
            op = ($urandom_range(0, 99) < ALLOC_PERCENT) ? OP_ALLOC : OP_RELEASE;
            // mostly slots inside the pool, so releases often hit live slots
            if ($urandom_range(0, 99) < IN_POOL_PERCENT)
               slot = SLOT_PORT_W'($urandom_range(0, pool_span - 1));
            else
               slot = SLOT_PORT_W'($urandom_range(0, 15));
            send_request(op, slot);
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d allocate and %0d release requests over %0d pool size writes,",
               allocs_sent, releases_sent, size_writes);
      $display("with clamped sizes, full-pool evictions and a long response hold-off");
      if (fail_count == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
